### hdl/vtig_pkg.sv
// ----------------------------------------------------------------------------
// vtig_pkg
// Shared types and constants for the video timing and interrupt generator.
// ----------------------------------------------------------------------------
package vtig_pkg;

    localparam int ACTIVE_LINES         = 200;
    localparam int VBLANK_START         = 400;
    localparam int HALF_LINES_PER_FRAME = 524;
    localparam int FRAMES_PER_SECOND    = 60;

    localparam int HALF_W  = 10;
    localparam int LINE_W  = 9;
    localparam int FRAME_W = 6;
    localparam int LADDR_W = $clog2(ACTIVE_LINES);

    // command codes
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_LINE_WRITE = 2'd1;
    localparam logic [1:0] CMD_ACK        = 2'd2;

    // register indexes
    localparam logic [1:0] REG_VBL_EN  = 2'd0;
    localparam logic [1:0] REG_QTR_EN  = 2'd1;
    localparam logic [1:0] REG_ONE_EN  = 2'd2;
    localparam logic [1:0] REG_SCAN_EN = 2'd3;

    // pending bit positions
    localparam int DIAG_VBL   = 0;
    localparam int DIAG_QTR   = 1;
    localparam int VGC_SCAN   = 0;
    localparam int VGC_ONESEC = 1;
    localparam int VGC_ANY    = 2;

    // clear mask bit positions
    localparam int CLR_VBL  = 0;
    localparam int CLR_QTR  = 1;
    localparam int CLR_ONE  = 2;
    localparam int CLR_SCAN = 3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] line_index;
        logic       line_irq_bit;
        logic [3:0] clear_mask;
    } in_t;

    typedef struct packed {
        logic       vblank_active;
        logic [8:0] vertical_count;
        logic [2:0] irq_raised;
        logic [1:0] diag_pending;
        logic [7:0] vgc_status;
        logic [5:0] frame_number;
    } out_t;

    typedef struct packed {
        logic vbl_en;
        logic qtr_en;
        logic one_en;
        logic scan_en;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [LADDR_W-1:0] addr;
        logic               value;
    } line_wr_t;

endpackage

### hdl/vtig_cfg_regs.sv
// ----------------------------------------------------------------------------
// vtig_cfg_regs
// APB register file holding the four interrupt enables.
// ----------------------------------------------------------------------------
module vtig_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output vtig_pkg::cfg_t     cfg
);

    vtig_pkg::cfg_t cfg_reg;
    logic [1:0]     idx;
    logic           wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                vtig_pkg::REG_VBL_EN:  cfg_reg.vbl_en  <= pwdata[0];
                vtig_pkg::REG_QTR_EN:  cfg_reg.qtr_en  <= pwdata[0];
                vtig_pkg::REG_ONE_EN:  cfg_reg.one_en  <= pwdata[0];
                vtig_pkg::REG_SCAN_EN: cfg_reg.scan_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            vtig_pkg::REG_VBL_EN:  prdata[0] = cfg_reg.vbl_en;
            vtig_pkg::REG_QTR_EN:  prdata[0] = cfg_reg.qtr_en;
            vtig_pkg::REG_ONE_EN:  prdata[0] = cfg_reg.one_en;
            vtig_pkg::REG_SCAN_EN: prdata[0] = cfg_reg.scan_en;
            default: ;
        endcase
    end

endmodule

### hdl/vtig_line_store.sv
// ----------------------------------------------------------------------------
// vtig_line_store
// Per-line interrupt bit memory with valid bits and a registered read of the
// line that the next tick will land on.
// ----------------------------------------------------------------------------
module vtig_line_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vtig_pkg::line_wr_t             wr,
    input  logic [vtig_pkg::LADDR_W-1:0]   rd_addr,
    output logic                           look_bit
);

    logic                          mem [vtig_pkg::ACTIVE_LINES];
    logic [vtig_pkg::ACTIVE_LINES-1:0] valid_reg;
    logic                          rdata_reg;
    logic                          rd_valid_reg;
    logic                          fwd_reg;
    logic                          fwd_bit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.value;
        end
        rdata_reg   <= mem[rd_addr];
        fwd_bit_reg <= wr.value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            // a write to the line being looked up wins over the stored copy
            fwd_reg      <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign look_bit = fwd_reg ? fwd_bit_reg : (rd_valid_reg & rdata_reg);

endmodule

### hdl/vtig_timing.sv
// ----------------------------------------------------------------------------
// vtig_timing
// Half-line and frame counters, pending bits and the result register.
// ----------------------------------------------------------------------------
module vtig_timing (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vtig_pkg::cfg_t                 cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  vtig_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output vtig_pkg::out_t                 m_data,
    output vtig_pkg::line_wr_t             line_wr,
    output logic [vtig_pkg::LADDR_W-1:0]   look_addr,
    input  logic                           look_bit
);

    localparam logic [vtig_pkg::HALF_W-1:0] HALF_WRAP =
        vtig_pkg::HALF_W'(vtig_pkg::HALF_LINES_PER_FRAME);
    localparam logic [vtig_pkg::HALF_W-1:0] HALF_VBL =
        vtig_pkg::HALF_W'(vtig_pkg::VBLANK_START);
    localparam logic [vtig_pkg::LINE_W-1:0] LINE_LIMIT =
        vtig_pkg::LINE_W'(vtig_pkg::ACTIVE_LINES);
    localparam logic [vtig_pkg::FRAME_W-1:0] FRAME_LAST =
        vtig_pkg::FRAME_W'(vtig_pkg::FRAMES_PER_SECOND - 1);
    localparam logic [vtig_pkg::FRAME_W-1:0] FRAME_Q1 = vtig_pkg::FRAME_W'(15);
    localparam logic [vtig_pkg::FRAME_W-1:0] FRAME_Q2 = vtig_pkg::FRAME_W'(30);
    localparam logic [vtig_pkg::FRAME_W-1:0] FRAME_Q3 = vtig_pkg::FRAME_W'(45);

    logic [vtig_pkg::HALF_W-1:0]  half_reg, half_next;
    logic [vtig_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic                         vbl_reg, vbl_next;
    logic [1:0]                   diag_reg, diag_next;
    logic [2:0]                   vgc_reg, vgc_next;
    logic                         m_valid_reg;
    vtig_pkg::out_t               m_data_reg;

    logic                         accept;
    logic [vtig_pkg::HALF_W-1:0]  h_inc, tgt_half;
    logic                         wrap;
    logic [vtig_pkg::LINE_W-1:0]  tgt_line;
    logic                         in_range;
    logic [vtig_pkg::HALF_W-1:0]  hn_inc, nxt_half;
    logic [vtig_pkg::LINE_W-1:0]  nxt_line;
    logic                         r_vbl, r_qtr, r_one, r_scan;
    logic                         qtr_frame;
    logic [2:0]                   raised;
    vtig_pkg::out_t               res;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // position that a tick from the current state lands on
    assign h_inc    = half_reg + 1'b1;
    assign wrap     = (h_inc >= HALF_WRAP);
    assign tgt_half = wrap ? '0 : h_inc;
    assign tgt_line = tgt_half[vtig_pkg::HALF_W-1:1];
    assign in_range = (tgt_line < LINE_LIMIT);

    assign qtr_frame = (frame_reg == '0) || (frame_reg == FRAME_Q1) ||
                       (frame_reg == FRAME_Q2) || (frame_reg == FRAME_Q3);

    always_comb begin
        half_next  = half_reg;
        frame_next = frame_reg;
        vbl_next   = vbl_reg;
        diag_next  = diag_reg;
        vgc_next   = vgc_reg;
        r_vbl      = 1'b0;
        r_qtr      = 1'b0;
        r_one      = 1'b0;
        r_scan     = 1'b0;
        line_wr    = '0;
        line_wr.addr  = s_data.line_index[vtig_pkg::LADDR_W-1:0];
        line_wr.value = s_data.line_irq_bit;

        if (accept) begin
            unique case (s_data.cmd)
                vtig_pkg::CMD_TICK: begin
                    half_next = tgt_half;
                    if (wrap) begin
                        vbl_next = 1'b0;
                        r_vbl = cfg.vbl_en && !diag_reg[vtig_pkg::DIAG_VBL];
                        r_qtr = qtr_frame && cfg.qtr_en && !diag_reg[vtig_pkg::DIAG_QTR];
                        r_one = cfg.one_en && (frame_reg == '0) &&
                                !vgc_reg[vtig_pkg::VGC_ONESEC];
                        frame_next = (frame_reg >= FRAME_LAST) ? '0 : frame_reg + 1'b1;
                    end else if (tgt_half == HALF_VBL) begin
                        vbl_next = 1'b1;
                    end
                    r_scan = cfg.scan_en && in_range && look_bit &&
                             !vgc_reg[vtig_pkg::VGC_SCAN];
                    if (r_vbl) diag_next[vtig_pkg::DIAG_VBL] = 1'b1;
                    if (r_qtr) diag_next[vtig_pkg::DIAG_QTR] = 1'b1;
                    if (r_one) begin
                        vgc_next[vtig_pkg::VGC_ONESEC] = 1'b1;
                        vgc_next[vtig_pkg::VGC_ANY]    = 1'b1;
                    end
                    if (r_scan) begin
                        vgc_next[vtig_pkg::VGC_SCAN] = 1'b1;
                        vgc_next[vtig_pkg::VGC_ANY]  = 1'b1;
                    end
                end
                vtig_pkg::CMD_LINE_WRITE: begin
                    line_wr.en = ({1'b0, s_data.line_index} < LINE_LIMIT);
                end
                vtig_pkg::CMD_ACK: begin
                    if (s_data.clear_mask[vtig_pkg::CLR_VBL])
                        diag_next[vtig_pkg::DIAG_VBL] = 1'b0;
                    if (s_data.clear_mask[vtig_pkg::CLR_QTR])
                        diag_next[vtig_pkg::DIAG_QTR] = 1'b0;
                    if (s_data.clear_mask[vtig_pkg::CLR_ONE])
                        vgc_next[vtig_pkg::VGC_ONESEC] = 1'b0;
                    if (s_data.clear_mask[vtig_pkg::CLR_SCAN])
                        vgc_next[vtig_pkg::VGC_SCAN] = 1'b0;
                    if (!vgc_next[vtig_pkg::VGC_ONESEC] && !vgc_next[vtig_pkg::VGC_SCAN])
                        vgc_next[vtig_pkg::VGC_ANY] = 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign raised = {2'b00, r_vbl} + {2'b00, r_qtr} + {2'b00, r_one} + {2'b00, r_scan};

    // look up the line that the following tick will land on
    assign hn_inc    = half_next + 1'b1;
    assign nxt_half  = (hn_inc >= HALF_WRAP) ? '0 : hn_inc;
    assign nxt_line  = nxt_half[vtig_pkg::HALF_W-1:1];
    assign look_addr = (nxt_line < LINE_LIMIT) ? nxt_line[vtig_pkg::LADDR_W-1:0] : '0;

    always_comb begin
        res.vblank_active  = vbl_next;
        res.vertical_count = half_next[vtig_pkg::HALF_W-1:1];
        res.irq_raised     = raised;
        res.diag_pending   = diag_next;
        res.vgc_status     = {vgc_next[vtig_pkg::VGC_ANY], vgc_next[vtig_pkg::VGC_ONESEC],
                              vgc_next[vtig_pkg::VGC_SCAN], 5'b00000};
        res.frame_number   = frame_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg    <= '0;
            frame_reg   <= '0;
            vbl_reg     <= 1'b0;
            diag_reg    <= '0;
            vgc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            half_reg  <= half_next;
            frame_reg <= frame_next;
            vbl_reg   <= vbl_next;
            diag_reg  <= diag_next;
            vgc_reg   <= vgc_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
    end

endmodule

### hdl/video_timing_irq_generator.sv
// ----------------------------------------------------------------------------
// video_timing_irq_generator
// Video timing counters and interrupt pending logic, top level.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries commands: tick (advance the half-line counter),
//   line write (set or clear the interrupt bit of one scanline) and
//   acknowledge (clear the pending bits picked by clear_mask).
//   m_* channel returns one result per command, showing the state after it:
//   vblank flag, current line, count of new requests, pending bits, status
//   byte and frame number.
//   The APB port holds four interrupt enables; write it only while idle.
// Timing:
//   One transfer in per cycle while s_ready is high; the registered result
//   appears in the cycle after the transfer. The line bit for the next tick
//   is pre-read from the line memory, so all commands run at one per cycle.
// Reset:
//   aresetn (synchronous) clears counters, pending bits, enables and the line
//   bit valid flags, so all line bits read as zero until written.
// Stall:
//   One result register; while it is full and m_ready is low, s_ready is low.
//   A result taken in the same cycle frees the slot for the next transfer.
// ----------------------------------------------------------------------------
module video_timing_irq_generator (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            s_valid,
    output logic            s_ready,
    input  vtig_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output vtig_pkg::out_t  m_data
);

    vtig_pkg::cfg_t                 cfg;
    vtig_pkg::line_wr_t             line_wr;
    logic [vtig_pkg::LADDR_W-1:0]   look_addr;
    logic                           look_bit;

    vtig_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vtig_line_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (line_wr),
        .rd_addr  (look_addr),
        .look_bit (look_bit)
    );

    vtig_timing u_timing (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .line_wr   (line_wr),
        .look_addr (look_addr),
        .look_bit  (look_bit)
    );

endmodule
